### rtl/jsl_pkg.sv
// shared types and constants for the joint state labeler
// depends on nothing; used by the interfaces, the cell and the top level
package jsl_pkg;

	localparam int MAX_STATES = 64;
	localparam int FRAC_BITS  = 8;
	localparam int VALUE_BITS = 32;
	localparam int OUT_W      = 7;
	localparam int KEY_W      = VALUE_BITS - FRAC_BITS;
	localparam int CNT_W      = $clog2(MAX_STATES + 1);
	localparam int IDX_W      = $clog2(MAX_STATES);

	// floored pair, integer part of each sample
	typedef struct packed {
		logic signed [KEY_W-1:0] a;
		logic signed [KEY_W-1:0] b;
	} pair_t;

	typedef logic [CNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] idx_t;

endpackage

### rtl/jsl_if.sv
// handshake channels of the joint state labeler: sample input and label output
// depends on jsl_pkg
interface jsl_sample_if
	import jsl_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] first_value;
	logic signed [VALUE_BITS-1:0] second_value;
	logic                         start_of_set;

	modport source (output valid, first_value, second_value, start_of_set, input ready);
	modport sink   (input valid, first_value, second_value, start_of_set, output ready);
endinterface

interface jsl_label_if
	import jsl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] joint_label;
	logic [OUT_W-1:0] label_bound;
	logic             overflow;

	modport source (output valid, joint_label, label_bound, overflow, input ready);
	modport sink   (input valid, joint_label, label_bound, overflow, output ready);
endinterface

### rtl/jsl_cell.sv
// one table cell: holds a floored pair, compares it with the probe, shifts right on append
// depends on jsl_pkg
module jsl_cell
	import jsl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  pair_t probe,
	input  logic  occupied,
	input  logic  shift,
	input  pair_t left,
	output pair_t stored,
	output logic  match
);

	pair_t pair_q;
	logic  match_q;

	// table payload, no reset
	always_ff @(posedge clk) begin
		if (shift) begin
			pair_q <= left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (load) begin
			match_q <= occupied && (pair_q == probe);
		end
	end

	assign stored = pair_q;
	assign match  = match_q;

endmodule

### rtl/joint_state_labeler.sv
// joint state labeler: dense first-appearance labels for floored sample pairs
// the compare result is registered in the cells; the label then goes to the output register once it has room
// each item takes a compare step, then an encode and append step; no new sample is taken until both are done
// the output register lets the next item in while a result waits to be taken
// reset clears the pair count and handshake state; table contents stay undefined
// depends on jsl_pkg, jsl_if and jsl_cell
module joint_state_labeler
	import jsl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	jsl_sample_if.sink   samples,
	jsl_label_if.source  labels
);

	// newest entry sits in cell 0; an entry at position p has label count - p
	pair_t                 chain [MAX_STATES+1];
	logic [MAX_STATES-1:0] match_vec;
	logic [MAX_STATES-1:0] occupied;

	pair_t  probe;
	logic   accept;
	logic   commit;
	logic   busy_q;
	logic   start_q;
	pair_t  key_q;
	count_t count_q;

	count_t eff_count;
	count_t new_count;
	logic   hit;
	logic   append;
	idx_t   hit_pos;
	count_t label;

	logic             out_valid_q;
	logic [OUT_W-1:0] joint_label_q;
	logic [OUT_W-1:0] label_bound_q;
	logic             overflow_q;

	// floor by dropping the fraction bits (arithmetic, toward minus infinity)
	assign probe.a = samples.first_value[VALUE_BITS-1:FRAC_BITS];
	assign probe.b = samples.second_value[VALUE_BITS-1:FRAC_BITS];

	assign samples.ready = !busy_q;
	assign accept        = samples.valid && samples.ready;
	// the encode and append step finishes only when the output register has room
	assign commit        = busy_q && (!out_valid_q || labels.ready);

	// a start transfer sees an empty table
	always_comb begin
		for (int i = 0; i < MAX_STATES; i++) begin
			occupied[i] = !samples.start_of_set && (count_t'(i) < count_q);
		end
	end

	assign chain[0] = key_q;

	genvar g;
	generate
		for (g = 0; g < MAX_STATES; g++) begin : g_cell
			jsl_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (accept),
				.probe    (probe),
				.occupied (occupied[g]),
				.shift    (commit && append),
				.left     (chain[g]),
				.stored   (chain[g+1]),
				.match    (match_vec[g])
			);
		end
	endgenerate

	// at most one cell matches, since stored pairs are distinct
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < MAX_STATES; i++) begin
			if (match_vec[i]) begin
				hit_pos = hit_pos | idx_t'(i);
			end
		end
	end

	assign eff_count = start_q ? '0 : count_q;
	assign hit       = |match_vec;
	assign append    = !hit && (eff_count < count_t'(MAX_STATES));
	assign new_count = eff_count + count_t'(append);

	always_comb begin
		if (hit) begin
			label = eff_count - count_t'(hit_pos);
		end else if (append) begin
			label = new_count;
		end else begin
			label = '0;
		end
	end

	// item control and pair count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				start_q <= samples.start_of_set;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				count_q <= new_count;
			end
		end
	end

	// probe key held for the append
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= probe;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (labels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			joint_label_q <= OUT_W'(label);
			label_bound_q <= OUT_W'(new_count + count_t'(1));
			overflow_q    <= !hit && !append;
		end
	end

	assign labels.valid       = out_valid_q;
	assign labels.joint_label = joint_label_q;
	assign labels.label_bound = label_bound_q;
	assign labels.overflow    = overflow_q;

`ifndef SYNTH
	// stored pairs are distinct, so the compare never hits twice
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> $onehot0(match_vec))
		else $error("more than one cell matched");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= count_t'(MAX_STATES))
		else $error("pair count above table size");

	// overflow only when nothing matched and the table was full
	assert property (@(posedge clk) disable iff (!arst_n)
		commit && !hit && !append |-> eff_count == count_t'(MAX_STATES))
		else $error("overflow with room in table");

	// count grows by at most one per committed item
	assert property (@(posedge clk) disable iff (!arst_n)
		commit && !start_q |=> count_q == $past(count_q) || count_q == $past(count_q) + 1'b1)
		else $error("pair count jumped");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// testbench for joint_state_labeler: a directed table, then random data sets under four idle mixes
// depends on jsl_pkg, jsl_if and joint_state_labeler from the rtl folder
module tb;
	import jsl_pkg::*;

	localparam int QUIET_LIMIT     = 2000;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int SETTLE_CYCLES   = 8;
	localparam int REPORT_LIMIT    = 10;
	localparam int POOL_MAX        = 80;
	localparam int DIRECTED_COUNT  = 23;

	// one result of the block, field by field
	typedef struct packed {
		logic [OUT_W-1:0] joint_label;
		logic [OUT_W-1:0] label_bound;
		logic             overflow;
	} label_rec_t;

	// one directed sample; typed rows carry the result that is checked, the rest use the predictor
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] first_value;
		logic signed [VALUE_BITS-1:0] second_value;
		logic                         start_of_set;
		logic                         typed;
		label_rec_t                   want;
	} directed_row_t;

	localparam label_rec_t NO_LABEL = '0;

	// the table-full case needs more than 64 distinct pairs, so it is reached by the
	// first random data set of every phase, which sweeps a pool of more than 64 pairs
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{32'h00000000, 32'h00000000, 1'b0, 1'b1, '{7'd1, 7'd2, 1'b0}}, // first pair after reset
		'{32'h000000FF, 32'h00000001, 1'b0, 1'b1, '{7'd1, 7'd2, 1'b0}}, // fraction bits only
		'{32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0, NO_LABEL},            // floors to minus one
		'{32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b0, NO_LABEL},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0, NO_LABEL},
		'{32'h80000000, 32'h80000000, 1'b0, 1'b0, NO_LABEL},
		'{32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, NO_LABEL},
		'{32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, NO_LABEL},
		'{32'h7FFFFF00, 32'h7FFFFFFF, 1'b0, 1'b0, NO_LABEL},            // same as the max pair
		'{32'h800000FF, 32'h80000000, 1'b0, 1'b0, NO_LABEL},            // same as the min pair
		'{32'h00000100, 32'h00000000, 1'b0, 1'b0, NO_LABEL},
		'{32'hFFFFFF00, 32'hFFFFFFFF, 1'b0, 1'b0, NO_LABEL},
		'{32'hFFFFFE01, 32'h00000000, 1'b0, 1'b0, NO_LABEL},            // negative floors down
		'{32'h12345678, 32'h9ABCDEF0, 1'b0, 1'b0, NO_LABEL},
		'{32'h9ABCDEF0, 32'h12345678, 1'b0, 1'b0, NO_LABEL},            // swapped pair is new
		'{32'h12345678, 32'h9ABCDEF0, 1'b1, 1'b1, '{7'd1, 7'd2, 1'b0}}, // start clears the table
		'{32'h00000000, 32'h00000000, 1'b0, 1'b0, NO_LABEL},
		'{32'h00000000, 32'h00000000, 1'b1, 1'b1, '{7'd1, 7'd2, 1'b0}},
		'{32'h00000000, 32'h00000000, 1'b1, 1'b1, '{7'd1, 7'd2, 1'b0}}, // back to back starts
		'{32'hAAAAAAAA, 32'h55555555, 1'b0, 1'b0, NO_LABEL},
		'{32'h55555555, 32'hAAAAAAAA, 1'b0, 1'b0, NO_LABEL},
		'{32'h00FF00FF, 32'hFF00FF00, 1'b0, 1'b0, NO_LABEL},
		'{32'h00000000, 32'h00000000, 1'b0, 1'b0, NO_LABEL}             // label already given
	};

	logic clk = 1'b0;
	logic arst_n;

	jsl_sample_if sample_ch ();
	jsl_label_if  label_ch ();

	joint_state_labeler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_ch),
		.labels (label_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle mix of the current phase, in percent of cycles
	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatch_count;

	label_rec_t pending_labels [$];

	// predictor state: floored pairs of the current data set, in label order
	pair_t seen_pairs [MAX_STATES];
	int    seen_count;

	// floor both samples, look the pair up and append it when new
	function automatic label_rec_t label_pair(logic signed [VALUE_BITS-1:0] x,
			logic signed [VALUE_BITS-1:0] y, logic start);
		pair_t      key;
		label_rec_t rec;
		int         hit;
		int         i;
		key.a = x[VALUE_BITS-1:FRAC_BITS];
		key.b = y[VALUE_BITS-1:FRAC_BITS];
		hit = 0;
		rec.overflow = 1'b0;
		if (start)
			seen_count = 0;
		for (i = 0; i < seen_count; i++)
			if (hit == 0 && seen_pairs[i] == key)
				hit = i + 1;
		if (hit == 0) begin
			if (seen_count < MAX_STATES) begin
				seen_pairs[seen_count] = key;
				seen_count++;
				hit = seen_count;
			end else begin
				rec.overflow = 1'b1;
			end
		end
		rec.joint_label = OUT_W'(hit);
		rec.label_bound = OUT_W'(seen_count + 1);
		return rec;
	endfunction

	// drive one sample until it transfers, then queue what it should produce
	task automatic offer_sample(logic signed [VALUE_BITS-1:0] x, logic signed [VALUE_BITS-1:0] y,
			logic start, logic typed, label_rec_t want);
		label_rec_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.first_value  <= x;
		sample_ch.second_value <= y;
		sample_ch.start_of_set <= start;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		predicted = label_pair(x, y, start);
		pending_labels.push_back(typed ? want : predicted);
	endtask

	// one data set: a start, a sweep through a pool of pairs with random fractions,
	// then repeats from the pool, with some random noise and, in small sets, stray starts
	task automatic run_data_set(int pool_size, int set_len, inout int sent);
		pair_t                        pool [POOL_MAX];
		logic signed [VALUE_BITS-1:0] x;
		logic signed [VALUE_BITS-1:0] y;
		logic                         start;
		int                           idx;
		int                           k;
		for (k = 0; k < pool_size; k++) begin
			pool[k].a = ($urandom_range(3) == 0) ? KEY_W'(int'($urandom_range(3)) - 2)
				: KEY_W'($urandom);
			pool[k].b = ($urandom_range(3) == 0) ? KEY_W'(int'($urandom_range(3)) - 2)
				: KEY_W'($urandom);
			// pairs that share one coordinate must still get separate labels
			if (k > 0 && $urandom_range(99) < 30)
				pool[k].a = pool[k-1].a;
		end
		for (k = 0; k < set_len; k++) begin
			start = (k == 0) || (pool_size < 40 && $urandom_range(99) < 3);
			if ($urandom_range(99) < 10) begin
				x = $urandom;
				y = $urandom;
			end else begin
				idx = (k < pool_size) ? k : $urandom_range(pool_size - 1);
				x = {pool[idx].a, FRAC_BITS'($urandom)};
				y = {pool[idx].b, FRAC_BITS'($urandom)};
			end
			offer_sample(x, y, start, 1'b0, NO_LABEL);
			sent++;
		end
	endtask

	// result side: random stalls, compare each transfer with the oldest expectation
	initial begin : label_monitor
		label_rec_t got;
		label_rec_t want;
		label_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (label_ch.valid && label_ch.ready) begin
				got = '{label_ch.joint_label, label_ch.label_bound, label_ch.overflow};
				if (pending_labels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result: label %0d bound %0d overflow %0b",
							got.joint_label, got.label_bound, got.overflow);
				end else begin
					want = pending_labels.pop_front();
					if (got.joint_label !== want.joint_label || got.label_bound !== want.label_bound
							|| got.overflow !== want.overflow) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("wrong result: expected %0d/%0d/%0b got %0d/%0d/%0b",
								want.joint_label, want.label_bound, want.overflow,
								got.joint_label, got.label_bound, got.overflow);
					end
				end
			end
			label_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// ends the run when neither channel has had a transfer for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (label_ch.valid && label_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("joint_state_labeler: mismatch");
		$finish;
	end

	initial begin : stimulus
		int row;
		int phase;
		int sent;
		int pool_size;
		int set_len;
		logic big_set;
		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.first_value  = '0;
		sample_ch.second_value = '0;
		sample_ch.start_of_set = 1'b0;
		sender_idle_pct        = 0;
		receiver_stall_pct     = 0;
		mismatch_count         = 0;
		seen_count             = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_COUNT; row++)
			offer_sample(DIRECTED_ROWS[row].first_value, DIRECTED_ROWS[row].second_value,
				DIRECTED_ROWS[row].start_of_set, DIRECTED_ROWS[row].typed,
				DIRECTED_ROWS[row].want);

		// phases: no idling, sender idle, receiver stalling, both
		for (phase = 0; phase < 4; phase++) begin
			sender_idle_pct    = (phase == 1) ? 72 : (phase == 3) ? 29 : 0;
			receiver_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 29 : 0;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				big_set = (sent == 0) || ($urandom_range(99) < 30);
				pool_size = big_set ? $urandom_range(72, 66) : $urandom_range(12, 1);
				set_len = big_set ? pool_size + $urandom_range(24, 8)
					: $urandom_range(3 * pool_size + 4, pool_size);
				run_data_set(pool_size, set_len, sent);
			end
		end
		sample_ch.valid <= 1'b0;

		while (pending_labels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("joint_state_labeler: match");
		else
			$display("joint_state_labeler: mismatch");
		$finish;
	end

endmodule

### filelist.f
rtl/jsl_pkg.sv
rtl/jsl_if.sv
rtl/jsl_cell.sv
rtl/joint_state_labeler.sv
test/tb.sv
